@@ sv/fph_pkg.sv @@
// Shared types and codes for the fit-policy hole allocator.
// No dependencies; used by fph_cell and fit_policy_hole_allocator_unit.
package fph_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLE_COUNT = 2'd1;

    // fit policy codes; the unused code behaves as first fit
    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    // item commands
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_REQUEST = 1'b1;

    localparam logic [21:0] TOTAL_MAX = 22'h3F_FFFF;

    typedef struct packed {
        logic        cmd;
        logic [5:0]  slot;
        logic [15:0] amount;
    } item_t;

    typedef struct packed {
        logic        granted;
        logic [11:0] request_number;
        logic [15:0] hole_size_before;
        logic [21:0] free_total;
    } result_t;

    // scan token control travelling down the cell row
    typedef struct packed {
        logic valid;
        logic found;
    } scan_ctl_t;

endpackage

@@ sv/fph_cell.sv @@
// One hole slot of the allocator row: holds a hole size and updates the scan token.
// Depends on fph_pkg (scan_ctl_t, fit policy codes).
module fph_cell #(
    parameter int INDEX     = 0,
    parameter int HOLES     = 64,
    parameter int SIZE_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  wr_en,
    input  logic [((HOLES > 1) ? $clog2(HOLES) : 1)-1:0] wr_slot,
    input  logic [SIZE_BITS-1:0]                  wr_data,
    input  logic [1:0]                            policy,
    input  logic [((SIZE_BITS > 16) ? SIZE_BITS : 16)-1:0] need,
    input  logic [$clog2(HOLES+1)-1:0]            used,
    input  fph_pkg::scan_ctl_t                    ctl_in,
    input  logic [((HOLES > 1) ? $clog2(HOLES) : 1)-1:0] pick_idx_in,
    input  logic [SIZE_BITS-1:0]                  pick_size_in,
    input  logic [SIZE_BITS+$clog2(HOLES+1)-1:0]  sum_in,
    output fph_pkg::scan_ctl_t                    ctl_out,
    output logic [((HOLES > 1) ? $clog2(HOLES) : 1)-1:0] pick_idx_out,
    output logic [SIZE_BITS-1:0]                  pick_size_out,
    output logic [SIZE_BITS+$clog2(HOLES+1)-1:0]  sum_out
);

    localparam int IDX_W  = (HOLES > 1) ? $clog2(HOLES) : 1;
    localparam int CNT_W  = $clog2(HOLES+1);
    localparam int NEED_W = (SIZE_BITS > 16) ? SIZE_BITS : 16;
    localparam int SUM_W  = SIZE_BITS + CNT_W;

    logic [SIZE_BITS-1:0] hole_reg;

    fph_pkg::scan_ctl_t   ctl_reg, ctl_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [SIZE_BITS-1:0] size_reg, size_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;

    logic active;
    logic fits;
    logic take;

    always_comb
    begin
        active = ctl_in.valid && (CNT_W'(INDEX) < used);
        fits   = NEED_W'(hole_reg) >= need;
        case (policy)
            fph_pkg::FIT_BEST:
            begin
                take = fits && (!ctl_in.found || hole_reg < pick_size_in);
            end
            fph_pkg::FIT_WORST:
            begin
                // largest hole wins; the fit check happens after the row
                take = !ctl_in.found || hole_reg > pick_size_in;
            end
            default:
            begin
                take = fits && !ctl_in.found;
            end
        endcase

        ctl_next.valid = ctl_in.valid;
        ctl_next.found = ctl_in.found || (active && take);
        idx_next       = (active && take) ? IDX_W'(INDEX) : pick_idx_in;
        size_next      = (active && take) ? hole_reg : pick_size_in;
        sum_next       = active ? (sum_in + SUM_W'(hole_reg)) : sum_in;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_slot == IDX_W'(INDEX))
        begin
            hole_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        size_reg <= size_next;
        sum_reg  <= sum_next;
    end

    assign ctl_out       = ctl_reg;
    assign pick_idx_out  = idx_reg;
    assign pick_size_out = size_reg;
    assign sum_out       = sum_reg;

endmodule

@@ sv/fit_policy_hole_allocator_unit.sv @@
// Top level of the fit-policy hole allocator: request control, config and cell row.
// Depends on fph_pkg and fph_cell.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+------------------------------
//   item     | item_valid/item_ready   | fph_pkg::item_t (cmd, slot, amount)
//   result   | result_valid/result_ready | fph_pkg::result_t
//   cfg      | cfg_valid/cfg_ready     | cfg_index, cfg_data (always ready)
//
// A load produces no result. A request sends the scan token across the row
// of HOLES registered cells, then the chosen hole is written back.
// One request is in flight at a time; a result waiting on result_ready
// holds the write-back and blocks new items.
// Reset returns control state and config to their defaults; hole sizes are undefined until loaded.
module fit_policy_hole_allocator_unit #(
    parameter int HOLES     = 64,
    parameter int SIZE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  fph_pkg::item_t                      item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output fph_pkg::result_t                    result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fph_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fph_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int IDX_W  = (HOLES > 1) ? $clog2(HOLES) : 1;
    localparam int CNT_W  = $clog2(HOLES+1);
    localparam int NEED_W = (SIZE_BITS > 16) ? SIZE_BITS : 16;
    localparam int SUM_W  = SIZE_BITS + CNT_W;
    localparam int TOT_W  = (SUM_W > 22) ? SUM_W : 22;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]           policy_reg;
    logic [6:0]           hole_count_reg;
    logic [11:0]          req_cnt_reg, req_cnt_next;
    logic                 start_reg, start_next;
    logic [NEED_W-1:0]    need_reg, need_next;
    logic                 grant_reg, grant_next;
    logic [IDX_W-1:0]     pick_reg, pick_next;
    logic [SIZE_BITS-1:0] before_reg, before_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic                 res_valid_reg, res_valid_next;
    fph_pkg::result_t     res_reg, res_next;

    logic                 item_fire;
    logic                 done_fire;
    logic                 slot_in_range;
    logic [CNT_W-1:0]     used;
    logic [31:0]          hc_ext;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_slot;
    logic [SIZE_BITS-1:0] wr_data;
    logic [TOT_W-1:0]     total_after;

    fph_pkg::scan_ctl_t   chain_ctl  [HOLES+1];
    logic [IDX_W-1:0]     chain_idx  [HOLES+1];
    logic [SIZE_BITS-1:0] chain_size [HOLES+1];
    logic [SUM_W-1:0]     chain_sum  [HOLES+1];

    assign cfg_ready    = 1'b1;
    assign item_ready   = (state_reg == ST_IDLE);
    assign item_fire    = item_valid && item_ready;
    assign done_fire    = (state_reg == ST_DONE) && (!res_valid_reg || result_ready);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    always_comb
    begin
        hc_ext        = 32'(hole_count_reg);
        used          = (hc_ext > HOLES) ? CNT_W'(HOLES) : CNT_W'(hc_ext);
        slot_in_range = 32'(item.slot) < HOLES;
    end

    // token entering the first cell
    assign chain_ctl[0].valid = start_reg;
    assign chain_ctl[0].found = 1'b0;
    assign chain_idx[0]       = '0;
    assign chain_size[0]      = '0;
    assign chain_sum[0]       = '0;

    genvar g;
    generate
        for (g = 0; g < HOLES; g++)
        begin : g_cell
            fph_cell #(
                .INDEX     (g),
                .HOLES     (HOLES),
                .SIZE_BITS (SIZE_BITS)
            ) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .wr_en         (wr_en),
                .wr_slot       (wr_slot),
                .wr_data       (wr_data),
                .policy        (policy_reg),
                .need          (need_reg),
                .used          (used),
                .ctl_in        (chain_ctl[g]),
                .pick_idx_in   (chain_idx[g]),
                .pick_size_in  (chain_size[g]),
                .sum_in        (chain_sum[g]),
                .ctl_out       (chain_ctl[g+1]),
                .pick_idx_out  (chain_idx[g+1]),
                .pick_size_out (chain_size[g+1]),
                .sum_out       (chain_sum[g+1])
            );
        end
    endgenerate

    // hole write: load on accept, or reduction of the chosen hole on completion
    always_comb
    begin
        if (done_fire)
        begin
            wr_en   = grant_reg;
            wr_slot = pick_reg;
            wr_data = SIZE_BITS'(NEED_W'(before_reg) - need_reg);
        end
        else
        begin
            wr_en   = item_fire && (item.cmd == fph_pkg::CMD_LOAD) && slot_in_range;
            wr_slot = IDX_W'(item.slot);
            wr_data = SIZE_BITS'(item.amount);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        start_next     = 1'b0;
        need_next      = need_reg;
        req_cnt_next   = req_cnt_reg;
        grant_next     = grant_reg;
        pick_next      = pick_reg;
        before_next    = before_reg;
        sum_next       = sum_reg;
        res_valid_next = res_valid_reg && !result_ready;
        res_next       = res_reg;

        // chosen hole is reduced by exactly the request, so the total drops by it
        total_after = TOT_W'(sum_reg) - (grant_reg ? TOT_W'(need_reg) : '0);

        case (state_reg)
            ST_IDLE:
            begin
                if (item_fire)
                begin
                    if (item.cmd == fph_pkg::CMD_LOAD)
                    begin
                        req_cnt_next = '0;
                    end
                    else
                    begin
                        need_next  = NEED_W'(item.amount);
                        start_next = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (chain_ctl[HOLES].valid)
                begin
                    // worst fit may carry a hole too small; recheck here
                    grant_next  = chain_ctl[HOLES].found &&
                                  (NEED_W'(chain_size[HOLES]) >= need_reg);
                    pick_next   = chain_idx[HOLES];
                    before_next = chain_size[HOLES];
                    sum_next    = chain_sum[HOLES];
                    state_next  = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (done_fire)
                begin
                    res_valid_next           = 1'b1;
                    res_next.granted         = grant_reg;
                    res_next.request_number  = req_cnt_reg;
                    res_next.hole_size_before = grant_reg ? 16'(before_reg) : 16'd0;
                    res_next.free_total      = (total_after > TOT_W'(fph_pkg::TOTAL_MAX)) ?
                                               fph_pkg::TOTAL_MAX : 22'(total_after);
                    req_cnt_next             = req_cnt_reg + 12'd1;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            start_reg      <= 1'b0;
            req_cnt_reg    <= '0;
            res_valid_reg  <= 1'b0;
            policy_reg     <= fph_pkg::FIT_FIRST;
            hole_count_reg <= 7'd1;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            req_cnt_reg   <= req_cnt_next;
            res_valid_reg <= res_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    fph_pkg::REG_FIT_POLICY: policy_reg     <= cfg_data[1:0];
                    fph_pkg::REG_HOLE_COUNT: hole_count_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        need_reg   <= need_next;
        grant_reg  <= grant_next;
        pick_reg   <= pick_next;
        before_reg <= before_next;
        sum_reg    <= sum_next;
        res_reg    <= res_next;
    end

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_req_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        item_fire && item.cmd == fph_pkg::CMD_REQUEST |=> state_reg == ST_SCAN && start_reg)
        else $error("request did not start a scan");

    a_token_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        chain_ctl[HOLES].valid |-> state_reg == ST_SCAN)
        else $error("scan token left the row outside a scan");

    a_no_grant_zero_size: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.granted |-> result.hole_size_before == 16'd0)
        else $error("refused request reports a hole size");

    a_load_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        item_fire && item.cmd == fph_pkg::CMD_LOAD |=> req_cnt_reg == 12'd0)
        else $error("load did not clear request counter");

endmodule

@@ tb/sv/fit_policy_hole_allocator_unit_tb.sv @@
// Testbench for fit_policy_hole_allocator_unit: first, best and worst fit
// allocation checked against a built-in predictor of the hole table.
// Depends on fph_pkg and the allocator RTL; self-contained otherwise.
module fit_policy_hole_allocator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLES       = 64;
    localparam int SIZE_BITS   = 16;
    localparam int ROW_LATENCY = HOLES + 16;
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;

    // policy code outside the defined set; the block treats it as first fit
    localparam logic [1:0] FIT_UNUSED = 2'd3;

    logic                                  clk          = 1'b0;
    logic                                  rst_n        = 1'b0;
    logic                                  item_valid   = 1'b0;
    logic                                  item_ready;
    fph_pkg::item_t                        item         = '0;
    logic                                  result_valid;
    logic                                  result_ready = 1'b0;
    fph_pkg::result_t                      result;
    logic                                  cfg_valid    = 1'b0;
    logic                                  cfg_ready;
    logic [fph_pkg::CFG_IDX_W-1:0]         cfg_index    = '0;
    logic [fph_pkg::CFG_DATA_W-1:0]        cfg_data     = '0;

    fph_pkg::item_t   item_backlog[$];
    fph_pkg::result_t awaited_grants[$];

    // predictor copy of the block state
    logic [SIZE_BITS-1:0] hole_table[HOLES];
    logic [11:0]          req_count;
    logic [1:0]           policy_q;
    logic [6:0]           count_q;

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          mismatches     = 0;
    int          quiet_cycles   = 0;
    logic [HOLES-1:0] loaded_map = '0;

    fit_policy_hole_allocator_unit #(
        .HOLES     (HOLES),
        .SIZE_BITS (SIZE_BITS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Expected outcome of one allocation request; updates the hole table.
    function automatic fph_pkg::result_t allocate_hole(input logic [SIZE_BITS-1:0] need);
        fph_pkg::result_t r;
        int               used;
        int               pick;
        int unsigned      sum;
        used = (count_q > HOLES) ? HOLES : int'(count_q);
        pick = -1;
        sum  = 0;
        for (int i = 0; i < used; i++)
        begin
            case (policy_q)
                fph_pkg::FIT_WORST:
                    if (pick < 0 || hole_table[i] > hole_table[pick])
                        pick = i;
                fph_pkg::FIT_BEST:
                    if (hole_table[i] >= need &&
                        (pick < 0 || hole_table[i] < hole_table[pick]))
                        pick = i;
                default:
                    if (pick < 0 && hole_table[i] >= need)
                        pick = i;
            endcase
        end
        // worst fit picks the largest hole first, then checks that it fits
        if (pick >= 0 && hole_table[pick] < need)
            pick = -1;
        r.granted          = (pick >= 0);
        r.request_number   = req_count;
        r.hole_size_before = '0;
        if (pick >= 0)
        begin
            r.hole_size_before = hole_table[pick];
            hole_table[pick]   = hole_table[pick] - need;
        end
        for (int i = 0; i < used; i++)
        begin
            sum += hole_table[i];
            if (sum > fph_pkg::TOTAL_MAX)
                sum = fph_pkg::TOTAL_MAX;
        end
        r.free_total = sum[21:0];
        req_count    = req_count + 12'd1;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input fph_pkg::result_t want,
                                   input fph_pkg::result_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t mismatch (%s): exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                     $realtime, what, want.granted, want.request_number,
                     want.hole_size_before, want.free_total, got.granted,
                     got.request_number, got.hole_size_before, got.free_total);
    endtask

    task automatic check_grant(input fph_pkg::result_t got);
        fph_pkg::result_t want;
        want = '0;
        if (awaited_grants.size() == 0)
        begin
            report_mismatch("no result expected", want, got);
            return;
        end
        want = awaited_grants.pop_front();
        if (got.granted !== want.granted || got.request_number !== want.request_number ||
            got.hole_size_before !== want.hole_size_before ||
            got.free_total !== want.free_total)
            report_mismatch("field", want, got);
    endtask

    // driver: one assignment to item_valid per edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid <= 1'b0;
        else if (!item_valid || item_ready)
        begin
            if (item_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                item_valid <= 1'b1;
                item       <= item_backlog.pop_front();
            end
            else
                item_valid <= 1'b0;
        end
    end

    // monitor: tracks config and items into the predictor, checks results
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            req_count    = '0;
            policy_q     = fph_pkg::FIT_FIRST;
            count_q      = 7'd1;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == fph_pkg::REG_FIT_POLICY)
                    policy_q = cfg_data[1:0];
                else if (cfg_index == fph_pkg::REG_HOLE_COUNT)
                    count_q = cfg_data;
            end
            if (item_valid && item_ready)
            begin
                if (item.cmd == fph_pkg::CMD_REQUEST)
                    awaited_grants.push_back(allocate_hole(item.amount));
                else
                begin
                    hole_table[item.slot] = item.amount;
                    req_count             = '0;
                end
            end
            if (result_valid && result_ready)
                check_grant(result);
            result_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles without any accepted transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && item_ready) || (result_valid && result_ready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles == STALL_LIMIT)
            begin
                $display("fit_policy_hole_allocator_unit verification failed");
                $finish;
            end
        end
    end

    function automatic logic [15:0] pick_amount();
        case ($urandom_range(5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 255));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic push_load(input int s, input logic [15:0] a);
        fph_pkg::item_t it;
        it.cmd    = fph_pkg::CMD_LOAD;
        it.slot   = 6'(s);
        it.amount = a;
        item_backlog.push_back(it);
        loaded_map[s] = 1'b1;
    endtask

    task automatic push_alloc(input logic [15:0] a);
        fph_pkg::item_t it;
        it.cmd    = fph_pkg::CMD_REQUEST;
        it.slot   = 6'($urandom_range(0, 63));
        it.amount = a;
        item_backlog.push_back(it);
    endtask

    // every slot that a request will scan must hold a loaded size
    task automatic fill_holes(input int used);
        for (int i = 0; i < used; i++)
            if (!loaded_map[i])
                push_load(i, pick_amount());
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (item_backlog.size() != 0 || item_valid || awaited_grants.size() != 0);
    endtask

    // loads give no result, so let the row settle before touching config
    task automatic settle();
        wait_drained();
        repeat (ROW_LATENCY) @(posedge clk);
    endtask

    task automatic write_reg(input logic [fph_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fph_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_mode(input logic [1:0] policy, input int count);
        settle();
        write_reg(fph_pkg::REG_FIT_POLICY, fph_pkg::CFG_DATA_W'(policy));
        write_reg(fph_pkg::REG_HOLE_COUNT, fph_pkg::CFG_DATA_W'(count));
    endtask

    task automatic random_phase(input logic [1:0] policy, input int count, input int send_pct,
                                input int stall_pct, input int n, input bit pressure);
        int used;
        int s;
        set_mode(policy, count);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        used = (count > HOLES) ? HOLES : count;
        fill_holes(used);
        for (int k = 0; k < n; k++)
        begin
            // hold the sender back until the pipeline is empty
            if (pressure && (k % 40) == 39)
                wait_drained();
            if ($urandom_range(99) < 25)
            begin
                if (used > 0 && $urandom_range(99) < 70)
                    s = $urandom_range(0, used - 1);
                else
                    s = $urandom_range(0, HOLES - 1);
                push_load(s, pick_amount());
            end
            else
                push_alloc(pick_amount());
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset config: first fit over slot zero only
        push_load(0, 16'hFFFF);
        push_load(63, 16'h1234);
        push_alloc(16'hFFFF);
        push_alloc(16'h0000);      // zero size fits an empty hole
        push_alloc(16'h0001);      // nothing fits

        set_mode(fph_pkg::FIT_FIRST, 0);    // no slot in use
        push_alloc(16'd5);
        push_alloc(16'd0);

        set_mode(fph_pkg::FIT_BEST, 4);
        push_load(1, 16'd20);
        push_load(2, 16'd30);
        push_load(3, 16'd20);
        push_load(0, 16'd50);
        push_alloc(16'd25);
        push_alloc(16'd20);        // tie between slots 1 and 3

        set_mode(fph_pkg::FIT_WORST, 4);
        push_alloc(16'd60);        // largest hole too small
        push_alloc(16'd10);

        set_mode(FIT_UNUSED, 4);
        push_alloc(16'd3);

        random_phase(fph_pkg::FIT_FIRST, 64, 0, 0, 48, 1'b0);
        random_phase(fph_pkg::FIT_BEST, $urandom_range(2, 63), 53, 0, 48, 1'b0);
        random_phase(fph_pkg::FIT_WORST, 127, 0, 53, 48, 1'b0);
        random_phase(FIT_UNUSED, $urandom_range(1, 64), 36, 36, 48, 1'b0);
        random_phase(fph_pkg::FIT_BEST, 64, 36, 36, 52, 1'b1);
        random_phase(fph_pkg::FIT_WORST, 1, 53, 0, 48, 1'b0);
        random_phase(fph_pkg::FIT_FIRST, 0, 0, 53, 32, 1'b0);
        random_phase(fph_pkg::FIT_BEST, $urandom_range(2, 63), 0, 0, 48, 1'b0);

        settle();
        if (mismatches == 0)
            $display("fit_policy_hole_allocator_unit verification clean");
        else
            $display("fit_policy_hole_allocator_unit verification failed");
        $finish;
    end

endmodule
